### rtl/core/dafmt_pkg.sv
// ----------------------------------------------------------------------------
// dafmt_pkg
// Shared types and constants for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package dafmt_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIGIT,
        ST_PLAN,
        ST_SIGN,
        ST_PADL,
        ST_TEXT,
        ST_PADR
    } state_t;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FILL_ZERO    = 3'd1;
    localparam logic [2:0] REG_ALIGN_MODE   = 3'd2;
    localparam logic [2:0] REG_COMMA_ENABLE = 3'd3;
    localparam logic [2:0] REG_SIGN_MODE    = 3'd4;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // floor(x / 10) == (x * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef struct packed {
        logic [31:0] quot;
        logic [3:0]  rem;
    } div10_res_t;

endpackage

### rtl/core/dafmt_div10.sv
// ----------------------------------------------------------------------------
// dafmt_div10
// Divide-by-ten unit: reciprocal multiply registered, then quotient and
// remainder formed from the registered product in the cycle after the dividend is presented.
// ----------------------------------------------------------------------------
module dafmt_div10
    import dafmt_pkg::*;
(
    input  logic        aclk,
    input  logic [31:0] dividend,
    output div10_res_t  res
);

    logic [63:0] prod_reg;
    logic [31:0] dividend_reg;
    logic [28:0] quot;
    logic [3:0]  tenq_lo;

    always_ff @(posedge aclk) begin
        prod_reg     <= {32'd0, dividend} * {32'd0, DIV10_MAGIC};
        dividend_reg <= dividend;
    end

    assign quot = prod_reg[63:DIV10_SHIFT];

    // remainder < 10, so the low nibble of x - 10q is enough
    assign tenq_lo = 4'({quot[0], 3'b000}) + 4'({quot[2:0], 1'b0});

    assign res.quot = {3'b000, quot};
    assign res.rem  = dividend_reg[3:0] - tenq_lo;

endmodule

### rtl/core/decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// decimal_ascii_formatter
// Signed 32-bit integer to decimal ASCII text, one character per output
// request, with optional commas, field width, fill and sign control.
// ----------------------------------------------------------------------------
// Sequencing: each decimal digit takes an ST_MUL and an ST_DIGIT state on the
//   shared divide-by-ten unit (multiply, then remainder), then ST_PLAN; the
//   characters follow, one per output transfer, held while the output is stalled.
// Flow: the input is not ready until the previous value's last character is out.
// Reset: aresetn synchronous, active low; clears the sequencer, the output
//   valid and all configuration registers.
// ----------------------------------------------------------------------------
module decimal_ascii_formatter
    import dafmt_pkg::*;
#(
    parameter int MAX_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast    // last_char
);

    state_t state_reg, state_next;

    logic [5:0] field_width_reg;
    logic       fill_zero_reg;
    logic [1:0] align_mode_reg;
    logic       comma_enable_reg;
    logic [1:0] sign_mode_reg;

    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [3:0]  digs_reg [10];
    logic [3:0]  nd_reg;
    logic [3:0]  pos_reg;
    logic [5:0]  padl_reg;
    logic [5:0]  padr_reg;
    logic [7:0]  sign_char_reg;

    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;

    div10_res_t  div_res;

    // plan signals
    logic [1:0]  n_commas;
    logic [3:0]  n_chars;
    logic [5:0]  w_sat;
    logic [3:0]  keep;
    logic [5:0]  pad_total;
    logic [5:0]  padl_plan;
    logic [5:0]  padr_plan;
    logic        has_sign;

    // emit signals
    logic        out_free;
    logic        emit;
    logic [7:0]  emit_char;
    logic        emit_last;
    logic        is_comma;
    logic [3:0]  dig_idx;
    logic [7:0]  fill_char;
    logic        cfg_wr;

    dafmt_div10 u_div10 (
        .aclk     (aclk),
        .dividend (mag_reg),
        .res      (div_res)
    );

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_width_reg  <= '0;
            fill_zero_reg    <= 1'b0;
            align_mode_reg   <= '0;
            comma_enable_reg <= 1'b0;
            sign_mode_reg    <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_FIELD_WIDTH:  field_width_reg  <= pwdata[5:0];
                REG_FILL_ZERO:    fill_zero_reg    <= pwdata[0];
                REG_ALIGN_MODE:   align_mode_reg   <= pwdata[1:0];
                REG_COMMA_ENABLE: comma_enable_reg <= pwdata[0];
                REG_SIGN_MODE:    sign_mode_reg    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FIELD_WIDTH:  prdata = {26'd0, field_width_reg};
            REG_FILL_ZERO:    prdata = {31'd0, fill_zero_reg};
            REG_ALIGN_MODE:   prdata = {30'd0, align_mode_reg};
            REG_COMMA_ENABLE: prdata = {31'd0, comma_enable_reg};
            REG_SIGN_MODE:    prdata = {30'd0, sign_mode_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Text plan: length, kept characters and padding
    // ------------------------------------------------------------------
    always_comb begin
        case (nd_reg)
            4'd4, 4'd5, 4'd6: n_commas = 2'd1;
            4'd7, 4'd8, 4'd9: n_commas = 2'd2;
            4'd10:            n_commas = 2'd3;
            default:          n_commas = 2'd0;
        endcase
        if (!comma_enable_reg) begin
            n_commas = 2'd0;
        end
    end

    assign n_chars = nd_reg + {2'b00, n_commas};
    assign w_sat   = (field_width_reg > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width_reg;

    always_comb begin
        keep      = n_chars;
        pad_total = '0;
        if (w_sat != '0) begin
            if (w_sat < {2'b00, n_chars}) begin
                keep = w_sat[3:0];
            end else begin
                pad_total = w_sat - {2'b00, n_chars};
            end
        end
    end

    // left alignment wins when both bits are set
    assign padr_plan = align_mode_reg[0] ? pad_total : '0;
    assign padl_plan = (!align_mode_reg[0] && align_mode_reg[1]) ? pad_total : '0;
    assign has_sign  = sign_mode_reg[0] || (!sign_mode_reg[1] && neg_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIGIT;
            ST_DIGIT: state_next = (div_res.quot == '0) ? ST_PLAN : ST_MUL;
            ST_PLAN: begin
                if (has_sign)              state_next = ST_SIGN;
                else if (padl_plan != '0)  state_next = ST_PADL;
                else                       state_next = ST_TEXT;
            end
            ST_SIGN: begin
                if (out_free) state_next = (padl_reg != '0) ? ST_PADL : ST_TEXT;
            end
            ST_PADL: begin
                if (out_free && padl_reg == 6'd1) state_next = ST_TEXT;
            end
            ST_TEXT: begin
                if (out_free && pos_reg == '0) begin
                    state_next = (padr_reg != '0) ? ST_PADR : ST_IDLE;
                end
            end
            ST_PADR: begin
                if (out_free && padr_reg == 6'd1) state_next = ST_IDLE;
            end
        endcase
    end

    assign fill_char = fill_zero_reg ? CH_ZERO : CH_SPACE;
    // text positions count from the lowest character; every fourth is a comma
    assign is_comma  = comma_enable_reg && (pos_reg[1:0] == 2'b11);
    assign dig_idx   = comma_enable_reg ? (pos_reg - {2'b00, pos_reg[3:2]}) : pos_reg;

    always_comb begin
        emit      = 1'b0;
        emit_char = fill_char;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_SIGN: begin
                emit      = out_free;
                emit_char = sign_char_reg;
            end
            ST_PADL: begin
                emit      = out_free;
            end
            ST_TEXT: begin
                emit      = out_free;
                emit_char = is_comma ? CH_COMMA : {4'h3, digs_reg[dig_idx]};
                emit_last = (pos_reg == '0) && (padr_reg == '0);
            end
            ST_PADR: begin
                emit      = out_free;
                emit_last = (padr_reg == 6'd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_reg <= s_tdata[31];
                    mag_reg <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
                    nd_reg  <= '0;
                end
            end
            ST_DIGIT: begin
                digs_reg[nd_reg] <= div_res.rem;
                nd_reg           <= nd_reg + 4'd1;
                mag_reg          <= div_res.quot;
            end
            ST_PLAN: begin
                pos_reg       <= keep - 4'd1;
                padl_reg      <= padl_plan;
                padr_reg      <= padr_plan;
                sign_char_reg <= neg_reg ? CH_MINUS : CH_PLUS;
            end
            ST_PADL: if (out_free) padl_reg <= padl_reg - 6'd1;
            ST_TEXT: if (out_free && pos_reg != '0) pos_reg <= pos_reg - 4'd1;
            ST_PADR: if (out_free) padr_reg <= padr_reg - 6'd1;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL))
        else $error("request accepted but divide not started");

    a_digit_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_DIGIT))
        else $error("divide result not consumed");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT) |-> (nd_reg < 4'd10))
        else $error("digit buffer overflow");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !emit)
        else $error("output overwritten while stalled");

endmodule
